FILE: rtl/core/srma_pkg.sv
`default_nettype none
package srma_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W        = 48;
   localparam int PAGE_BITS     = 12;
   localparam int PAGE_CNT_W    = 37;
   localparam int REQ_DATA_W    = 136;
   localparam int RSP_DATA_W    = 64;

   typedef enum logic [1:0] {
      REQ_APPEND    = 2'd0,
      REQ_ALLOC_TOP = 2'd1,
      REQ_ALLOC_AT  = 2'd2,
      REQ_FREE      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PASS_WRITE  = 2'd0,
      PASS_INSERT = 2'd1,
      PASS_DEL1   = 2'd2,
      PASS_DEL2   = 2'd3
   } pass_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_ALIGN,
      S_SCAN,
      S_TD_END,
      S_BS,
      S_RT,
      S_NB,
      S_FWD,
      S_CARVE0,
      S_CARVE1,
      S_EDIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic              taken;
   } entry_type;

   typedef struct packed {
      logic      shift;
      entry_type push;
   } ring_ctl_type;

   typedef struct packed {
      pass_kind_type    kind;
      logic [IDX_W-1:0] pos;
      entry_type        val;
   } pass_type;

   typedef struct packed {
      req_code_type          code;
      logic [ADDR_W-1:0]     address;
      logic [PAGE_CNT_W-1:0] num_pages;
      logic [ADDR_W-1:0]     append_size;
      logic                  append_allocated;
   } request_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] result_address;
      logic [CNT_W-1:0]  entries_used;
   } response_type;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_range_map_allocator_top.sv
// Flow: a table full or invalid request is answered straight from the check; an append
//   realigns the ring, then runs one insert pass.
// Requests: one at a time; a top-down allocation realigns, scans the whole ring and runs
//   one to three edit passes; allocate-at and free add ring seeks for a binary search and,
//   for allocate-at, a step through the ranges above the target, then edits.
// Reset: synchronous, active high; clears the entry count and the control state only.
`default_nettype none
module sorted_range_map_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address [47:0], pages [84:48], append_size [132:85],
   // append_allocated [133], zero pad [135:134]
   input  logic [srma_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_address [47:0], entries_used [56:48], zero pad [63:57]
   output logic [srma_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]                      rsp_tuser
);
   import srma_pkg::*;

   request_type  req;
   response_type rsp;
   ring_ctl_type ring_ctl;
   entry_type    head, nxt1, nxt2;

   // unpack the request beat
   assign req.code             = req_code_type'(req_tuser);
   assign req.address          = req_tdata[ADDR_W-1:0];
   assign req.num_pages        = req_tdata[ADDR_W+PAGE_CNT_W-1:ADDR_W];
   assign req.append_size      = req_tdata[2*ADDR_W+PAGE_CNT_W-1:ADDR_W+PAGE_CNT_W];
   assign req.append_allocated = req_tdata[2*ADDR_W+PAGE_CNT_W];

   // the controller walks the table as it rotates past the head of the cell chain
   srma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp),
      .ring_ctl  (ring_ctl),
      .head      (head),
      .nxt1      (nxt1),
      .nxt2      (nxt2)
   );

   // one cell per table entry, rotating toward the head on each shift
   srma_ring u_ring (
      .clock (clock),
      .ctl   (ring_ctl),
      .head  (head),
      .nxt1  (nxt1),
      .nxt2  (nxt2)
   );

   // pack the result beat
   assign rsp_tdata = {{(RSP_DATA_W-ADDR_W-CNT_W){1'b0}}, rsp.entries_used,
                       rsp.result_address};
   assign rsp_tuser = rsp.status;

endmodule
`default_nettype wire

FILE: rtl/core/srma_cell.sv
`default_nettype none
module srma_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  srma_pkg::entry_type d_in,
   output srma_pkg::entry_type q_out
);
   import srma_pkg::*;

   entry_type entry_ff;

   // advance one place toward the head on every shift
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= d_in;
      end
   end

   assign q_out = entry_ff;

endmodule
`default_nettype wire

FILE: rtl/core/srma_ring.sv
`default_nettype none
module srma_ring (
   input  logic                   clock,
   input  srma_pkg::ring_ctl_type ctl,
   output srma_pkg::entry_type    head,
   output srma_pkg::entry_type    nxt1,
   output srma_pkg::entry_type    nxt2
);
   import srma_pkg::*;

   entry_type q [TABLE_ENTRIES];

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      if (k == TABLE_ENTRIES - 1) begin : g_tail
         srma_cell u_cell (
            .clock    (clock),
            .shift_en (ctl.shift),
            .d_in     (ctl.push),
            .q_out    (q[k])
         );
      end else begin : g_body
         srma_cell u_cell (
            .clock    (clock),
            .shift_en (ctl.shift),
            .d_in     (q[k+1]),
            .q_out    (q[k])
         );
      end
   end

   assign head = q[0];
   assign nxt1 = q[1];
   assign nxt2 = q[2];

endmodule
`default_nettype wire

FILE: rtl/core/srma_ctrl.sv
`default_nettype none
module srma_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  srma_pkg::request_type  in_req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output srma_pkg::response_type out_rsp,
   output srma_pkg::ring_ctl_type ring_ctl,
   input  srma_pkg::entry_type    head,
   input  srma_pkg::entry_type    nxt1,
   input  srma_pkg::entry_type    nxt2
);
   import srma_pkg::*;

   localparam int BSW = CNT_W + 1;
   localparam logic signed [BSW-1:0] ONE_S = BSW'(1);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_ENTRIES - 1);

   state_type             state_ff, state_in, after_ff, after_in;
   logic [IDX_W-1:0]      hpos_ff, hpos_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   entry_type             prev_ff, prev_in, carry_ff, carry_in;
   req_code_type          code_ff, code_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in, bytes_ff, bytes_in, asize_ff, asize_in;
   logic [PAGE_CNT_W-1:0] pages_ff, pages_in;
   logic                  atype_ff, atype_in;
   logic signed [BSW-1:0] left_ff, left_in, right_ff, right_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  found_ff, found_in, bad_ff, bad_in, nt_ff, nt_in;
   entry_type             cap_c_ff, cap_c_in, cap_p_ff, cap_p_in, cap_x_ff, cap_x_in;
   logic [ADDR_W+1:0]     ns_ff, ns_in, ne_ff, ne_in;
   logic [ADDR_W:0]       ce_ff, ce_in, pend_ff, pend_in;
   pass_type              pq_ff [3];
   pass_type              pq_in [3];
   logic [1:0]            pcnt_ff, pcnt_in;
   status_type            status_ff, status_in;
   logic [ADDR_W-1:0]     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   response_type          rsp_ff, rsp_in;

   logic signed [BSW-1:0] mid;
   logic [ADDR_W:0]       head_end, upper, asum;
   logic [ADDR_W:0]       hi, lo, rhs, lhs, sumpl, sumxl;
   logic                  full, lhs_nz, rhs_nz, mb, ma;
   entry_type             e_left, e_mid, e_right, e_pm1, e_pm2, e_xm, e_retype;
   logic [IDX_W-1:0]      p_idx, p_dec, p_inc, p_inc2;

   always_comb begin
      mid      = left_ff + ((right_ff - left_ff) >>> 1);
      head_end = {1'b0, head.start} + {1'b0, head.length};
      upper    = {1'b0, addr_ff} + {1'b0, bytes_ff};
      asum     = {1'b0, addr_ff} + {1'b0, asize_ff};
      hi       = (head_end < upper) ? head_end : upper;
      lo       = ({1'b0, head.start} > {1'b0, addr_ff}) ? {1'b0, head.start}
                                                        : {1'b0, addr_ff};
      full     = (code_ff == REQ_APPEND)
               ? ({1'b0, used_ff} + BSW'(1) > BSW'(TABLE_ENTRIES))
               : ({1'b0, used_ff} + BSW'(2) > BSW'(TABLE_ENTRIES));
      rhs      = ce_ff - ne_ff[ADDR_W:0];
      lhs      = ns_ff[ADDR_W:0] - {1'b0, cap_c_ff.start};
      lhs_nz   = ns_ff != {2'b0, cap_c_ff.start};
      rhs_nz   = {1'b0, ce_ff} != ne_ff;
      sumpl    = {1'b0, cap_p_ff.length} + {1'b0, bytes_ff};
      sumxl    = {1'b0, cap_x_ff.length} + {1'b0, bytes_ff};
      mb       = (idx_ff != '0) && (cap_p_ff.taken == nt_ff) && ({1'b0, pend_ff} == ns_ff);
      ma       = ((idx_ff + CNT_W'(1)) < used_ff) && (cap_x_ff.taken == nt_ff)
               && ({2'b0, cap_x_ff.start} == ne_ff);
      p_idx    = idx_ff[IDX_W-1:0];
      p_dec    = p_idx - IDX_W'(1);
      p_inc    = p_idx + IDX_W'(1);
      p_inc2   = p_idx + IDX_W'(2);
      e_left   = '{start: cap_c_ff.start, length: lhs[ADDR_W-1:0], taken: cap_c_ff.taken};
      e_mid    = '{start: ns_ff[ADDR_W-1:0], length: bytes_ff, taken: nt_ff};
      e_right  = '{start: ne_ff[ADDR_W-1:0], length: rhs[ADDR_W-1:0], taken: cap_c_ff.taken};
      e_pm1    = '{start: cap_p_ff.start, length: sumpl[ADDR_W-1:0], taken: cap_p_ff.taken};
      e_pm2    = '{start: cap_p_ff.start,
                   length: sumpl[ADDR_W-1:0] + cap_x_ff.length, taken: cap_p_ff.taken};
      e_xm     = '{start: ns_ff[ADDR_W-1:0], length: sumxl[ADDR_W-1:0],
                   taken: cap_x_ff.taken};
      e_retype = '{start: cap_c_ff.start, length: cap_c_ff.length, taken: nt_ff};
   end

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      hpos_in      = hpos_ff;
      used_in      = used_ff;
      prev_in      = prev_ff;
      carry_in     = carry_ff;
      code_in      = code_ff;
      addr_in      = addr_ff;
      bytes_in     = bytes_ff;
      asize_in     = asize_ff;
      pages_in     = pages_ff;
      atype_in     = atype_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      bad_in       = bad_ff;
      nt_in        = nt_ff;
      cap_c_in     = cap_c_ff;
      cap_p_in     = cap_p_ff;
      cap_x_in     = cap_x_ff;
      ns_in        = ns_ff;
      ne_in        = ne_ff;
      ce_in        = ce_ff;
      pend_in      = pend_ff;
      pq_in        = pq_ff;
      pcnt_in      = pcnt_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      in_ready     = 1'b0;
      ring_ctl     = '{shift: 1'b0, push: head};

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               code_in   = in_req.code;
               addr_in   = in_req.address;
               pages_in  = in_req.num_pages;
               bytes_in  = ADDR_W'({in_req.num_pages, {PAGE_BITS{1'b0}}});
               asize_in  = {in_req.append_size[ADDR_W-1:1], 1'b0};
               atype_in  = in_req.append_allocated;
               res_in    = '0;
               status_in = ST_OK;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (full) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else if (code_ff == REQ_APPEND) begin
               if (asize_ff == '0 || asum[ADDR_W]) begin
                  status_in = ST_INVALID;
                  state_in  = S_RESP;
               end else begin
                  pq_in[0]  = '{kind: PASS_INSERT, pos: used_ff[IDX_W-1:0],
                                val: '{start: addr_ff, length: asize_ff, taken: atype_ff}};
                  pcnt_in   = 2'd1;
                  after_in  = S_EDIT;
                  state_in  = S_ALIGN;
               end
            end else if (pages_ff == '0 ||
                         pages_ff[PAGE_CNT_W-1:ADDR_W-PAGE_BITS] != '0) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else if (code_ff == REQ_ALLOC_TOP) begin
               found_in = 1'b0;
               after_in = S_SCAN;
               state_in = S_ALIGN;
            end else if (code_ff == REQ_ALLOC_AT && upper[ADDR_W]) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               left_in  = '0;
               right_in = $signed({1'b0, used_ff}) - ONE_S;
               state_in = S_BS;
            end
         end
         S_ALIGN: begin
            if (hpos_ff != '0) begin
               ring_ctl.shift = 1'b1;
            end else begin
               state_in = after_ff;
            end
         end
         S_SCAN: begin
            ring_ctl.shift = 1'b1;
            if ({1'b0, hpos_ff} < used_ff && !head.taken && head.length >= bytes_ff) begin
               found_in = 1'b1;
               idx_in   = {1'b0, hpos_ff};
               cap_c_in = head;
               cap_p_in = prev_ff;
               cap_x_in = nxt1;
            end
            if (hpos_ff == LAST_POS) begin
               state_in = S_TD_END;
            end
         end
         S_TD_END: begin
            if (!found_ff) begin
               status_in = ST_NOMEM;
               state_in  = S_RESP;
            end else begin
               ns_in    = {2'b0, cap_c_ff.start} + {2'b0, cap_c_ff.length}
                        - {2'b0, bytes_ff};
               nt_in    = 1'b1;
               state_in = S_CARVE0;
            end
         end
         S_BS: begin
            if (left_ff > right_ff) begin
               state_in = S_RT;
            end else if (hpos_ff != mid[IDX_W-1:0]) begin
               ring_ctl.shift = 1'b1;
            end else if (head.start < addr_ff) begin
               left_in = mid + ONE_S;
            end else if (addr_ff < head.start) begin
               right_in = mid - ONE_S;
            end else begin
               idx_in   = CNT_W'(mid);
               state_in = (code_ff == REQ_FREE) ? S_NB : S_FWD;
            end
         end
         S_RT: begin
            if (right_ff < 0 || (hpos_ff == right_ff[IDX_W-1:0] &&
                !(head.start < addr_ff && {1'b0, addr_ff} < head_end))) begin
               // no range holds the address: allocate-at falls back to the next range up
               if (code_ff == REQ_ALLOC_AT && left_ff != $signed({1'b0, used_ff})) begin
                  idx_in   = CNT_W'(left_ff);
                  state_in = S_FWD;
               end else begin
                  status_in = (code_ff == REQ_FREE) ? ST_INVALID : ST_NOMEM;
                  state_in  = S_RESP;
               end
            end else if (hpos_ff != right_ff[IDX_W-1:0]) begin
               ring_ctl.shift = 1'b1;
            end else begin
               idx_in   = CNT_W'(right_ff);
               state_in = (code_ff == REQ_FREE) ? S_NB : S_FWD;
            end
         end
         S_NB: begin
            if (hpos_ff != p_idx) begin
               ring_ctl.shift = 1'b1;
            end else begin
               cap_c_in = head;
               cap_p_in = prev_ff;
               cap_x_in = nxt1;
               ns_in    = {2'b0, addr_ff};
               nt_in    = 1'b0;
               state_in = S_CARVE0;
            end
         end
         S_FWD: begin
            priority if (idx_ff >= used_ff) begin
               status_in = ST_NOMEM;
               state_in  = S_RESP;
            end else if (hpos_ff != p_idx) begin
               ring_ctl.shift = 1'b1;
            end else if ({1'b0, head.start} > upper) begin
               status_in = ST_NOMEM;
               state_in  = S_RESP;
            end else if (!head.taken && hi > lo && (hi - lo) >= {1'b0, bytes_ff}) begin
               cap_c_in = head;
               cap_p_in = prev_ff;
               cap_x_in = nxt1;
               ns_in    = {1'b0, lo};
               nt_in    = 1'b1;
               state_in = S_CARVE0;
            end else if (head_end >= upper || (upper - head_end) < {1'b0, bytes_ff}) begin
               status_in = ST_NOMEM;
               state_in  = S_RESP;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_CARVE0: begin
            ce_in    = {1'b0, cap_c_ff.start} + {1'b0, cap_c_ff.length};
            ne_in    = ns_ff + {2'b0, bytes_ff};
            pend_in  = {1'b0, cap_p_ff.start} + {1'b0, cap_p_ff.length};
            bad_in   = ({2'b0, cap_c_ff.start} > ns_ff) || (cap_c_ff.taken == nt_ff);
            state_in = S_CARVE1;
         end
         S_CARVE1: begin
            if (bad_ff || {1'b0, ce_ff} < ne_ff) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               status_in = ST_OK;
               res_in    = (code_ff == REQ_FREE) ? '0 : ns_ff[ADDR_W-1:0];
               after_in  = S_EDIT;
               state_in  = S_ALIGN;
               priority if (lhs_nz && rhs_nz) begin
                  pq_in[0] = '{kind: PASS_WRITE,  pos: p_idx,  val: e_left};
                  pq_in[1] = '{kind: PASS_INSERT, pos: p_inc,  val: e_mid};
                  pq_in[2] = '{kind: PASS_INSERT, pos: p_inc2, val: e_right};
                  pcnt_in  = 2'd3;
               end else if (rhs_nz) begin
                  if (mb) begin
                     pq_in[0] = '{kind: PASS_WRITE, pos: p_dec, val: e_pm1};
                     pq_in[1] = '{kind: PASS_WRITE, pos: p_idx, val: e_right};
                  end else begin
                     pq_in[0] = '{kind: PASS_WRITE,  pos: p_idx, val: e_mid};
                     pq_in[1] = '{kind: PASS_INSERT, pos: p_inc, val: e_right};
                  end
                  pcnt_in = 2'd2;
               end else if (lhs_nz) begin
                  pq_in[0] = '{kind: PASS_WRITE, pos: p_idx, val: e_left};
                  if (ma) begin
                     pq_in[1] = '{kind: PASS_WRITE, pos: p_inc, val: e_xm};
                  end else begin
                     pq_in[1] = '{kind: PASS_INSERT, pos: p_inc, val: e_mid};
                  end
                  pcnt_in = 2'd2;
               end else if (mb && ma) begin
                  pq_in[0] = '{kind: PASS_WRITE, pos: p_dec, val: e_pm2};
                  pq_in[1] = '{kind: PASS_DEL2,  pos: p_idx, val: e_pm2};
                  pcnt_in  = 2'd2;
               end else if (mb) begin
                  pq_in[0] = '{kind: PASS_WRITE, pos: p_dec, val: e_pm1};
                  pq_in[1] = '{kind: PASS_DEL1,  pos: p_idx, val: e_pm1};
                  pcnt_in  = 2'd2;
               end else if (ma) begin
                  pq_in[0] = '{kind: PASS_WRITE, pos: p_inc, val: e_xm};
                  pq_in[1] = '{kind: PASS_DEL1,  pos: p_idx, val: e_xm};
                  pcnt_in  = 2'd2;
               end else begin
                  pq_in[0] = '{kind: PASS_WRITE, pos: p_idx, val: e_retype};
                  pcnt_in  = 2'd1;
               end
            end
         end
         S_EDIT: begin
            ring_ctl.shift = 1'b1;
            unique case (pq_ff[0].kind)
               PASS_WRITE: begin
                  if (hpos_ff == pq_ff[0].pos) begin
                     ring_ctl.push = pq_ff[0].val;
                  end
               end
               PASS_INSERT: begin
                  if (hpos_ff == pq_ff[0].pos) begin
                     ring_ctl.push = pq_ff[0].val;
                     carry_in      = head;
                  end else if (hpos_ff > pq_ff[0].pos) begin
                     ring_ctl.push = carry_ff;
                     carry_in      = head;
                  end
               end
               PASS_DEL1: begin
                  if (hpos_ff >= pq_ff[0].pos) begin
                     ring_ctl.push = nxt1;
                  end
               end
               PASS_DEL2: begin
                  if (hpos_ff >= pq_ff[0].pos) begin
                     ring_ctl.push = nxt2;
                  end
               end
               default: ;
            endcase
            if (hpos_ff == LAST_POS) begin
               unique case (pq_ff[0].kind)
                  PASS_WRITE:  used_in = used_ff;
                  PASS_INSERT: used_in = used_ff + CNT_W'(1);
                  PASS_DEL1:   used_in = used_ff - CNT_W'(1);
                  PASS_DEL2:   used_in = used_ff - CNT_W'(2);
                  default:     used_in = used_ff;
               endcase
               pq_in[0] = pq_ff[1];
               pq_in[1] = pq_ff[2];
               pcnt_in  = pcnt_ff - 2'd1;
               if (pcnt_ff == 2'd1) begin
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, result_address: res_ff,
                                entries_used: used_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ring_ctl.shift) begin
         hpos_in = (hpos_ff == LAST_POS) ? '0 : hpos_ff + IDX_W'(1);
         prev_in = ring_ctl.push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hpos_ff      <= '0;
         used_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hpos_ff      <= hpos_in;
         used_ff      <= used_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      after_ff  <= after_in;
      prev_ff   <= prev_in;
      carry_ff  <= carry_in;
      code_ff   <= code_in;
      addr_ff   <= addr_in;
      bytes_ff  <= bytes_in;
      asize_ff  <= asize_in;
      pages_ff  <= pages_in;
      atype_ff  <= atype_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      bad_ff    <= bad_in;
      nt_ff     <= nt_in;
      cap_c_ff  <= cap_c_in;
      cap_p_ff  <= cap_p_in;
      cap_x_ff  <= cap_x_in;
      ns_ff     <= ns_in;
      ne_ff     <= ne_in;
      ce_ff     <= ce_in;
      pend_ff   <= pend_in;
      pq_ff     <= pq_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

FILE: dv/srma_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module srma_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [srma_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [srma_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                      rsp_tuser,
   output int                              errors,
   output int                              pending
);
   import srma_pkg::*;

   localparam logic [63:0] AMASK = (64'd1 << ADDR_W) - 64'd1;

   // shadow copy of the range table
   logic [63:0] tbl_start [TABLE_ENTRIES];
   logic [63:0] tbl_len   [TABLE_ENTRIES];
   bit          tbl_taken [TABLE_ENTRIES];
   int          n_used;

   response_type answers_due [$];

   function automatic logic [63:0] span_end(int i);
      return tbl_start[i] + tbl_len[i];
   endfunction

   function automatic void put_range(int i, logic [63:0] s, logic [63:0] l, bit t);
      tbl_start[i] = s & AMASK;
      tbl_len[i]   = l & AMASK;
      tbl_taken[i] = t;
   endfunction

   function automatic void open_slot(int i, logic [63:0] s, logic [63:0] l, bit t);
      if (n_used >= TABLE_ENTRIES || i > n_used) return;
      for (int j = n_used; j > i; j--) begin
         tbl_start[j] = tbl_start[j-1];
         tbl_len[j]   = tbl_len[j-1];
         tbl_taken[j] = tbl_taken[j-1];
      end
      n_used++;
      put_range(i, s, l, t);
   endfunction

   function automatic void close_slots(int i, int k);
      if (i + k > n_used) return;
      for (int j = i; j + k < n_used; j++) begin
         tbl_start[j] = tbl_start[j+k];
         tbl_len[j]   = tbl_len[j+k];
         tbl_taken[j] = tbl_taken[j+k];
      end
      n_used -= k;
   endfunction

   // binary search; with above set, fall back to the next range above value
   function automatic int locate_span(logic [63:0] value, bit above);
      int left, right, mid;
      left  = 0;
      right = n_used - 1;
      while (left <= right) begin
         mid = left + (right - left) / 2;
         if (tbl_start[mid] < value) left = mid + 1;
         else if (value < tbl_start[mid]) right = mid - 1;
         else return mid;
      end
      if (right >= 0 && tbl_start[right] < value && value < span_end(right)) return right;
      if (left == n_used) left = -1;
      return above ? left : -1;
   endfunction

   // retype [ns, ns+nl) inside range idx, splitting and coalescing
   function automatic status_type retype(int idx, logic [63:0] ns, logic [63:0] nl, bit nt);
      logic [63:0] cs, ce, ne, lhs, rhs;
      bit ct, mb, ma;
      cs = tbl_start[idx];
      ce = span_end(idx);
      ne = ns + nl;
      ct = tbl_taken[idx];
      if (cs > ns || ce < ne || ct == nt) return ST_INVALID;
      lhs = ns - cs;
      rhs = ce - ne;
      if (lhs != 0 && rhs != 0) begin
         put_range(idx, cs, lhs, ct);
         open_slot(idx + 1, ns, nl, nt);
         open_slot(idx + 2, ne, rhs, ct);
         return ST_OK;
      end
      mb = idx > 0 && tbl_taken[idx-1] == nt && span_end(idx - 1) == ns;
      if (lhs == 0 && rhs != 0) begin
         if (mb) begin
            tbl_len[idx-1] = (tbl_len[idx-1] + nl) & AMASK;
            put_range(idx, ne, rhs, ct);
         end else begin
            put_range(idx, ns, nl, nt);
            open_slot(idx + 1, ne, rhs, ct);
         end
         return ST_OK;
      end
      ma = idx + 1 < n_used && tbl_taken[idx+1] == nt && tbl_start[idx+1] == ne;
      if (lhs != 0) begin
         put_range(idx, cs, lhs, ct);
         if (ma) begin
            tbl_start[idx+1] = ns;
            tbl_len[idx+1]   = (tbl_len[idx+1] + nl) & AMASK;
         end else begin
            open_slot(idx + 1, ns, nl, nt);
         end
         return ST_OK;
      end
      if (!mb && !ma) begin
         tbl_taken[idx] = nt;
      end else if (mb && ma) begin
         tbl_len[idx-1] = (tbl_len[idx-1] + nl + tbl_len[idx+1]) & AMASK;
         close_slots(idx, 2);
      end else if (mb) begin
         tbl_len[idx-1] = (tbl_len[idx-1] + nl) & AMASK;
         close_slots(idx, 1);
      end else begin
         tbl_start[idx+1] = ns;
         tbl_len[idx+1]   = (tbl_len[idx+1] + nl) & AMASK;
         close_slots(idx, 1);
      end
      return ST_OK;
   endfunction

   function automatic response_type serve_request(request_type rq);
      response_type r;
      logic [63:0] addr, pages, asize, bytes, lower, upper, s, e, hi, lo, ns;
      int need, i, idx;
      bit hit;
      addr  = 64'(rq.address);
      pages = 64'(rq.num_pages);
      asize = 64'(rq.append_size) & ~64'd1;
      bytes = pages << PAGE_BITS;
      need  = (rq.code == REQ_APPEND) ? 1 : 2;
      r.status = ST_OK;
      r.result_address = '0;
      if (n_used + need > TABLE_ENTRIES) begin
         r.status = ST_FULL;
      end else if (rq.code == REQ_APPEND) begin
         if (asize == 0 || addr + asize > AMASK) r.status = ST_INVALID;
         else open_slot(n_used, addr, asize, rq.append_allocated);
      end else if (pages == 0 || pages > (AMASK >> PAGE_BITS)) begin
         r.status = ST_INVALID;
      end else if (rq.code == REQ_ALLOC_TOP) begin
         hit = 0;
         for (i = n_used - 1; i >= 0; i--) begin
            if (!tbl_taken[i] && tbl_len[i] >= bytes) begin
               hit = 1;
               break;
            end
         end
         if (!hit) begin
            r.status = ST_NOMEM;
         end else begin
            ns = span_end(i) - bytes;
            r.status = retype(i, ns, bytes, 1'b1);
            if (r.status == ST_OK) r.result_address = ns[ADDR_W-1:0];
         end
      end else if (rq.code == REQ_ALLOC_AT) begin
         lower = addr;
         upper = addr + bytes;
         hit = 0;
         if (upper > AMASK) begin
            r.status = ST_INVALID;
         end else begin
            idx = locate_span(lower, 1'b1);
            if (idx >= 0) begin
               for (; idx < n_used; idx++) begin
                  s = tbl_start[idx];
                  e = span_end(idx);
                  if (s > upper) break;
                  if (!tbl_taken[idx]) begin
                     hi = (e < upper) ? e : upper;
                     lo = (s > lower) ? s : lower;
                     if (hi > lo && hi - lo >= bytes) begin
                        hit = 1;
                        break;
                     end
                  end
                  if (e >= upper || upper - e < bytes) break;
               end
            end
            if (!hit) begin
               r.status = ST_NOMEM;
            end else begin
               s  = tbl_start[idx];
               ns = (lower > s) ? lower : s;
               r.status = retype(idx, ns, bytes, 1'b1);
               if (r.status == ST_OK) r.result_address = ns[ADDR_W-1:0];
            end
         end
      end else begin
         idx = locate_span(addr, 1'b0);
         if (idx < 0) r.status = ST_INVALID;
         else r.status = retype(idx, addr, bytes, 1'b0);
      end
      r.entries_used = n_used[CNT_W-1:0];
      return r;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      request_type  rq;
      response_type want, got;
      if (reset) begin
         n_used = 0;
         answers_due.delete();
         errors = 0;
      end else begin
         // predict on every accepted request beat
         if (req_tvalid && req_tready) begin
            rq.code             = req_code_type'(req_tuser);
            rq.address          = req_tdata[47:0];
            rq.num_pages        = req_tdata[84:48];
            rq.append_size      = req_tdata[132:85];
            rq.append_allocated = req_tdata[133];
            answers_due.push_back(serve_request(rq));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status         = status_type'(rsp_tuser);
            got.result_address = rsp_tdata[47:0];
            got.entries_used   = rsp_tdata[56:48];
            if (answers_due.size() == 0) begin
               $error("unexpected response beat");
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors++;
               end
               if (got.result_address !== want.result_address) begin
                  $error("result_address: expected %h, actual %h",
                         want.result_address, got.result_address);
                  errors++;
               end
               if (got.entries_used !== want.entries_used) begin
                  $error("entries_used: expected %0d, actual %0d",
                         want.entries_used, got.entries_used);
                  errors++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: dv/tb_sorted_range_map_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_range_map_allocator_top;
   import srma_pkg::*;

   localparam logic [47:0] POOL_BASE = 48'h0000_1000_0000;
   localparam logic [47:0] ONES48    = '1;
   localparam logic [36:0] ONES37    = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   int                    errors;
   int                    pending;

   // sender burst bookkeeping
   int          beats_left;
   // next free address for contiguous appends, and past allocate-at targets
   logic [47:0] pool_top;
   logic [47:0] claimed [$];

   sorted_range_map_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   srma_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #400ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: random stalls, with long always-ready stretches and one long
   // hold-off so the block backs up and drops req_tready.
   initial begin
      int cyc;
      bit steady;
      cyc = 0;
      steady = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 700 == 0) steady = ($urandom_range(0, 2) == 0);
         if (cyc >= 3000 && cyc < 9000) rsp_tready <= 1'b0;
         else if (steady) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // Drive one request beat and hold it until accepted. Between bursts,
   // drop tvalid for a random gap.
   task automatic send_req(req_code_type code, logic [47:0] addr, logic [36:0] pages,
                           logic [47:0] size, bit taken);
      int gap;
      if (beats_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         beats_left = $urandom_range(1, 20);
      end
      beats_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {2'b00, taken, size, pages, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic append_pages(int n, bit taken);
      send_req(REQ_APPEND, pool_top, '0, 48'(n) << PAGE_BITS, taken);
      pool_top = pool_top + (48'(n) << PAGE_BITS);
   endtask

   function automatic logic [47:0] pool_pick();
      return POOL_BASE + (48'($urandom_range(0, 32'((pool_top - POOL_BASE) >> PAGE_BITS)))
                          << PAGE_BITS);
   endfunction

   initial begin
      logic [47:0] a;
      int sel;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_APPEND;
      beats_left  = 0;
      pool_top    = POOL_BASE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: build a small pool, then hit each corner
      append_pages(4, 1'b0);
      append_pages(4, 1'b1);
      append_pages(8, 1'b0);
      append_pages(6, 1'b1);
      send_req(REQ_APPEND, POOL_BASE, '0, '0, 1'b0);          // zero size
      send_req(REQ_APPEND, POOL_BASE, '0, 48'd1, 1'b1);       // size clears to zero
      send_req(REQ_APPEND, ONES48, '0, 48'd2, 1'b0);          // ends above the top
      send_req(REQ_APPEND, 48'd1, '0, ONES48, 1'b1);          // size clears to even, still fits below the top
      send_req(REQ_ALLOC_TOP, '0, '0, '0, 1'b0);              // zero pages
      send_req(REQ_ALLOC_TOP, '0, ONES37, '0, 1'b0);          // page count too big
      send_req(REQ_ALLOC_TOP, '0, 37'h0F_FFFF_FFFF, '0, 1'b0); // legal, no fit
      send_req(REQ_ALLOC_TOP, '0, 37'd2, '0, 1'b0);
      send_req(REQ_ALLOC_AT, ONES48, 37'd1, '0, 1'b0);        // beyond the top
      send_req(REQ_ALLOC_AT, POOL_BASE + 48'h1000, 37'd1, '0, 1'b0);
      send_req(REQ_ALLOC_AT, POOL_BASE + 48'h0123, 37'd1, '0, 1'b0);
      send_req(REQ_ALLOC_AT, 48'h8000_0000_0000, 37'd1, '0, 1'b0);
      send_req(REQ_ALLOC_AT, '0, 37'd40, '0, 1'b0);           // ends below the pool, no fit
      send_req(REQ_FREE, POOL_BASE + 48'h1000, 37'd1, '0, 1'b0);
      send_req(REQ_FREE, POOL_BASE + 48'h1000, 37'd1, '0, 1'b0); // already free
      send_req(REQ_FREE, 48'h10, 37'd1, '0, 1'b0);            // in no range
      send_req(REQ_FREE, POOL_BASE + 48'h5000, 37'd30, '0, 1'b0); // past range end
      send_req(REQ_FREE, POOL_BASE + 48'h4000, 37'd4, '0, 1'b0);  // whole range

      // random: mostly well-formed traffic inside the pool, some noise
      for (int n = 0; n < 760; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            if ($urandom_range(0, 4) == 0) pool_top = pool_top + 48'h2000;
            append_pages($urandom_range(1, 16), 1'($urandom_range(0, 1)));
         end else if (sel < 33) begin
            send_req(REQ_ALLOC_TOP, rand48(),
                     ($urandom_range(0, 9) == 0) ? 37'($urandom_range(9, 64))
                                                 : 37'($urandom_range(1, 8)),
                     rand48(), 1'($urandom_range(0, 1)));
         end else if (sel < 60) begin
            a = pool_pick();
            if ($urandom_range(0, 9) == 0) a = a + 48'($urandom_range(1, 4095));
            claimed.push_back(a);
            send_req(REQ_ALLOC_AT, a, 37'($urandom_range(1, 8)), rand48(),
                     1'($urandom_range(0, 1)));
         end else if (sel < 90) begin
            a = (claimed.size() > 0 && $urandom_range(0, 1))
                ? claimed[$urandom_range(0, claimed.size() - 1)] : pool_pick();
            send_req(REQ_FREE, a, 37'($urandom_range(1, 4)), rand48(),
                     1'($urandom_range(0, 1)));
         end else begin
            send_req(req_code_type'($urandom_range(0, 3)), rand48(),
                     37'({$urandom(), $urandom()}), rand48(), 1'($urandom_range(0, 1)));
         end
      end

      // fill the table until appends and allocations report it full
      for (int n = 0; n < 270; n++) begin
         append_pages(1, n[0]);
         if (n % 30 == 29) send_req(REQ_ALLOC_TOP, '0, 37'd1, '0, 1'b0);
      end

      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (4000) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
